[src/efx_pkg.sv]
package efx_pkg;

	localparam int WORD_W = 64;
	localparam int SEED_W = 32;
	localparam int ROT_AMOUNT = 25;

	// Digits of the remainder unit: bits folded in per cycle.
	localparam int MOD_BITS = 4;
	localparam int MOD_STEPS = WORD_W / MOD_BITS;

	// Seed positions of the four registers, then the start of the tables.
	localparam int SEED_POS_A = 0;
	localparam int SEED_POS_B = 1;
	localparam int SEED_POS_C = 2;
	localparam int SEED_POS_I = 3;
	localparam int SEED_POS_TABLES = 4;

	// One iteration seed word covers a group of four table entries.
	localparam int GROUP_SIZE = 4;
	localparam int GROUP_SHIFT = 2;
	localparam logic [GROUP_SHIFT-1:0] FILL_LAST = GROUP_SHIFT'(GROUP_SIZE - 1);

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t i;
	} regs_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_ADV,
		ST_MOD,
		ST_READ,
		ST_WRITE
	} state_t;

endpackage

[src/efx_in_if.sv]
interface efx_in_if import efx_pkg::*;;
	logic              valid;
	logic              ready;
	logic              mode;
	logic [SEED_W-1:0] seed_word;

	modport source (output valid, output mode, output seed_word, input ready);
	modport sink (input valid, input mode, input seed_word, output ready);
endinterface

[src/efx_out_if.sv]
interface efx_out_if import efx_pkg::*;;
	logic  valid;
	logic  ready;
	word_t random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

[src/efiix64_random_generator_core.sv]
// Channel  Dir  Payload                      Word
// req      in   mode, seed_word[31:0]        one seed word or one generate request
// rsp      out  random_value[63:0]           one generator output per generate request
//
// One generator step (advance) takes ADV, MOD, READ and WRITE states; MOD waits for
// the remainder units that reduce the counter and reg_c to table indexes, which are
// serial unless the table depth is a power of two.
// A generate request takes one step; an iteration group word adds a fill of four table
// writes, and the last seed word adds ITER_DEPTH steps.
// Reset clears the generator registers and marks every table entry as zero.
// req is taken only in the idle state; a result waiting on rsp stalls only the
// write cycle of the next generate step; until that step starts, seed words are still taken.
module efiix64_random_generator_core import efx_pkg::*; #(
	parameter int ITER_DEPTH  = 32,
	parameter int INDIR_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	efx_in_if.sink    req,
	efx_out_if.source rsp
);

	localparam int IT_AW       = $clog2(ITER_DEPTH);
	localparam int IN_AW       = $clog2(INDIR_DEPTH);
	localparam int ITER_GROUPS = (ITER_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int SEED_WORDS  = SEED_POS_TABLES + ITER_GROUPS + INDIR_DEPTH;
	localparam int POS_W       = $clog2(SEED_WORDS);
	localparam int FAW         = $clog2(ITER_DEPTH + GROUP_SIZE);
	localparam int WW          = $clog2(ITER_DEPTH);

	localparam logic [POS_W-1:0] POS_A     = POS_W'(SEED_POS_A);
	localparam logic [POS_W-1:0] POS_B     = POS_W'(SEED_POS_B);
	localparam logic [POS_W-1:0] POS_C     = POS_W'(SEED_POS_C);
	localparam logic [POS_W-1:0] POS_I     = POS_W'(SEED_POS_I);
	localparam logic [POS_W-1:0] POS_ITER  = POS_W'(SEED_POS_TABLES);
	localparam logic [POS_W-1:0] POS_INDIR = POS_W'(SEED_POS_TABLES + ITER_GROUPS);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(SEED_WORDS - 1);

	state_t state_q, state_d;

	regs_t             regs_q;
	logic [POS_W-1:0]  pos_q;
	logic [WW-1:0]     warm_q;
	logic              gen_q;
	word_t             seed_q;
	logic [FAW-1:0]    fill_addr_q;
	logic [GROUP_SHIFT-1:0] fill_k_q;
	logic              rsp_valid_q;
	word_t             rsp_data_q;

	logic req_ready;
	logic req_acc;
	logic mod_start;
	logic rd_en;
	logic fire;

	logic [IT_AW-1:0] it_idx;
	logic [IN_AW-1:0] in_idx;
	logic             it_done;
	logic             in_done;

	word_t iter_rd;
	word_t indir_rd;
	regs_t regs_nxt;
	word_t indir_wdata;
	word_t iter_wdata;
	word_t step_result;

	logic             iter_we;
	logic [IT_AW-1:0] iter_waddr;
	word_t            iter_wd;
	logic             indir_we;
	logic [IN_AW-1:0] indir_waddr;
	word_t            indir_wd;

	logic  seed_in_group;
	logic  seed_in_indir;
	logic  seed_last;
	word_t seed_ext;

	assign req_acc  = req.valid & req_ready;
	assign seed_ext = {{(WORD_W - SEED_W){1'b0}}, req.seed_word};

	// Where the current seed word goes.
	assign seed_in_group = (pos_q >= POS_ITER) && (pos_q < POS_INDIR);
	assign seed_in_indir = pos_q >= POS_INDIR;
	assign seed_last     = pos_q == POS_LAST;

	// Sequencer: idle, a four-entry group fill, or one or more generator steps.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		mod_start = 1'b0;
		rd_en     = 1'b0;
		fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_acc) begin
					if (req.mode) begin
						state_d = ST_ADV;
					end else if (seed_in_group) begin
						state_d = ST_FILL;
					end else if (seed_last) begin
						state_d = ST_ADV;
					end
				end
			end
			ST_FILL: begin
				if (fill_k_q == FILL_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_ADV: begin
				mod_start = 1'b1;
				state_d   = ST_MOD;
			end
			ST_MOD: begin
				if (it_done && in_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				// A generate step commits only once the output register can take it.
				if (!(gen_q && rsp_valid_q && !rsp.ready)) begin
					fire = 1'b1;
					if (warm_q != '0) begin
						state_d = ST_ADV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Generator registers, seed position and step bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q      <= '0;
			pos_q       <= '0;
			warm_q      <= '0;
			gen_q       <= 1'b0;
			fill_k_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_acc) begin
				gen_q <= req.mode;
				if (!req.mode) begin
					if (pos_q == POS_A) begin
						regs_q.a <= seed_ext;
					end
					if (pos_q == POS_B) begin
						regs_q.b <= seed_ext;
					end
					if (pos_q == POS_C) begin
						regs_q.c <= seed_ext;
					end
					if (pos_q == POS_I) begin
						regs_q.i <= seed_ext;
					end
					fill_k_q <= '0;
					if (seed_last) begin
						// Seeding done: run ITER_DEPTH warm-up steps, results dropped.
						pos_q  <= '0;
						warm_q <= WW'(ITER_DEPTH - 1);
						gen_q  <= 1'b0;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
			end
			if (state_q == ST_FILL) begin
				fill_k_q <= fill_k_q + GROUP_SHIFT'(1);
			end
			if (fire) begin
				regs_q <= regs_nxt;
				if (warm_q != '0) begin
					warm_q <= warm_q - WW'(1);
				end
				if (gen_q) begin
					rsp_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && !req.mode && seed_in_group) begin
			seed_q      <= seed_ext;
			fill_addr_q <= FAW'(pos_q - POS_ITER) << GROUP_SHIFT;
		end else if (state_q == ST_FILL) begin
			fill_addr_q <= fill_addr_q + FAW'(1);
		end
		if (fire && gen_q) begin
			rsp_data_q <= step_result;
		end
	end

	// Table indexes: step counter modulo ITER_DEPTH, reg_c modulo INDIR_DEPTH.
	efx_mod_unit #(
		.DIVISOR(ITER_DEPTH)
	) u_it_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.value (regs_q.i),
		.rem   (it_idx),
		.done  (it_done)
	);

	efx_mod_unit #(
		.DIVISOR(INDIR_DEPTH)
	) u_in_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.value (regs_q.c),
		.rem   (in_idx),
		.done  (in_done)
	);

	// Iteration table: written by group fills (entries past the end are skipped) or by a step.
	assign iter_we    = fire || ((state_q == ST_FILL) && (fill_addr_q < FAW'(ITER_DEPTH)));
	assign iter_waddr = fire ? it_idx : fill_addr_q[IT_AW-1:0];
	assign iter_wd    = fire ? iter_wdata : seed_q;

	// Indirection table: written by its seed words or by a step.
	assign indir_we    = fire || (req_acc && !req.mode && seed_in_indir);
	assign indir_waddr = fire ? in_idx : IN_AW'(pos_q - POS_INDIR);
	assign indir_wd    = fire ? indir_wdata : seed_ext;

	efx_table_mem #(
		.DEPTH(ITER_DEPTH)
	) u_iter_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (iter_we),
		.waddr (iter_waddr),
		.wdata (iter_wd),
		.re    (rd_en),
		.raddr (it_idx),
		.rdata (iter_rd)
	);

	efx_table_mem #(
		.DEPTH(INDIR_DEPTH)
	) u_indir_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (indir_we),
		.waddr (indir_waddr),
		.wdata (indir_wd),
		.re    (rd_en),
		.raddr (in_idx),
		.rdata (indir_rd)
	);

	// The step datapath is shared by generate requests and warm-up steps.
	efx_step_unit u_step (
		.cur        (regs_q),
		.iterated   (iter_rd),
		.indirect   (indir_rd),
		.nxt        (regs_nxt),
		.indir_wdata(indir_wdata),
		.iter_wdata (iter_wdata),
		.result     (step_result)
	);

	assign req.ready        = req_ready;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.random_value = rsp_data_q;

endmodule

[src/efx_table_mem.sv]
module efx_table_mem import efx_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  word_t                    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output word_t                    rdata
);

	word_t            mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	word_t            rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

[src/efx_mod_unit.sv]
module efx_mod_unit import efx_pkg::*; #(
	parameter int DIVISOR = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  word_t                      value,
	output logic [$clog2(DIVISOR)-1:0] rem,
	output logic                       done
);

	localparam int RW = $clog2(DIVISOR);
	localparam int CW = $clog2(MOD_STEPS + 1);

	logic [RW-1:0] rem_q;
	logic          done_q;

	generate
		if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_pow2
			// A power of two needs only the low bits.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else if (start) begin
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= value[RW-1:0];
				end
			end
		end else begin : g_serial
			// Long division, MOD_BITS bits of the dividend per cycle, from the top.
			word_t         sh_q;
			logic [CW-1:0] cnt_q;
			logic [RW-1:0] rem_d;

			always_comb begin
				logic [RW:0] r;
				r = {1'b0, rem_q};
				for (int k = 0; k < MOD_BITS; k++) begin
					r = {r[RW-1:0], sh_q[WORD_W-1-k]};
					if (r >= (RW + 1)'(DIVISOR)) begin
						r = r - (RW + 1)'(DIVISOR);
					end
				end
				rem_d = r[RW-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					done_q <= 1'b0;
					cnt_q  <= CW'(MOD_STEPS);
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						done_q <= 1'b1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= value;
					rem_q <= '0;
				end else if (cnt_q != '0) begin
					sh_q  <= sh_q << MOD_BITS;
					rem_q <= rem_d;
				end
			end
		end
	endgenerate

	assign rem  = rem_q;
	assign done = done_q;

endmodule

[src/efx_step_unit.sv]
module efx_step_unit import efx_pkg::*; (
	input  regs_t cur,
	input  word_t iterated,
	input  word_t indirect,
	output regs_t nxt,
	output word_t indir_wdata,
	output word_t iter_wdata,
	output word_t result
);

	word_t mix;
	word_t rot;

	assign mix = cur.a ^ cur.b;
	assign rot = (cur.c << ROT_AMOUNT) | (cur.c >> (WORD_W - ROT_AMOUNT));

	assign nxt.a = cur.b + cur.i;
	assign nxt.b = cur.c + indirect;
	assign nxt.c = mix + rot;
	assign nxt.i = cur.i + WORD_W'(1);

	assign indir_wdata = iterated + cur.a;
	assign iter_wdata  = indirect;
	assign result      = nxt.b ^ iterated;

endmodule

[tb/testbench.sv]
// Self-checking bench for the efiix64 generator core.
//
// The bench keeps its own copy of the generator state: the four 64-bit
// registers, both tables and the position within the seed sequence. Every
// word that the core accepts on req is applied to that copy at the same
// clock edge. A generate request adds the predicted output to a queue. A
// seed word only changes the copy. A checker pops one prediction for every
// result taken on rsp and compares it with random_value.
module testbench;
	import efx_pkg::*;

	// The core runs with its default table sizes. The seed sequence length
	// follows from them: four registers, one word per group of four
	// iteration entries, then one word per indirection entry.
	localparam int ITER_DEPTH = 32;
	localparam int INDIR_DEPTH = 16;
	localparam int ITER_GROUPS = (ITER_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int SEED_WORDS = SEED_POS_TABLES + ITER_GROUPS + INDIR_DEPTH;

	localparam logic MODE_SEED = 1'b0;
	localparam logic MODE_GEN = 1'b1;

	localparam int RANDOM_WORDS = 650;
	localparam int STEADY_FROM = 300;
	localparam int STEADY_TO = 420;
	localparam int IDLE_PERCENT = 13;
	localparam int HOLD_CYCLES = 400;
	// The last seed word triggers ITER_DEPTH warm-up steps, so the tail wait
	// and the watchdog both leave room for them.
	localparam int DRAIN_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT = 10;

	logic clk;
	logic arst_n;

	efx_in_if req_if ();
	efx_out_if rsp_if ();

	efiix64_random_generator_core #(
		.ITER_DEPTH  (ITER_DEPTH),
		.INDIR_DEPTH (INDIR_DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Predicted generator state.
	word_t iter_tbl [ITER_DEPTH];
	word_t indir_tbl [INDIR_DEPTH];
	word_t gen_a;
	word_t gen_b;
	word_t gen_c;
	word_t gen_count;
	int unsigned seed_pos;

	// Outputs that the core still owes, oldest first.
	word_t expected_values [$];

	int words_sent;
	int mismatches;
	int quiet_cycles;
	// Set while both sides run without idling.
	bit steady;
	// Asks the receiver process for one long hold-off.
	bit stall_sink_req;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Clears the predicted state to what reset leaves in the core.
	function automatic void predictor_reset();
		foreach (iter_tbl[k])
			iter_tbl[k] = '0;
		foreach (indir_tbl[k])
			indir_tbl[k] = '0;
		gen_a = '0;
		gen_b = '0;
		gen_c = '0;
		gen_count = '0;
		seed_pos = 0;
	endfunction

	// One generator step. The two table words trade places through the
	// registers: the iteration entry picked by the counter takes the old
	// indirection word, and the indirection entry picked by reg_c takes the
	// old iteration word plus reg_a. The output is the new reg_b XOR the old
	// iteration word.
	function automatic word_t prng_advance();
		int unsigned it_idx;
		int unsigned in_idx;
		word_t iterated;
		word_t indirect;
		word_t mix;
		it_idx = int'(gen_count % ITER_DEPTH);
		in_idx = int'(gen_c % INDIR_DEPTH);
		iterated = iter_tbl[it_idx];
		indirect = indir_tbl[in_idx];
		indir_tbl[in_idx] = iterated + gen_a;
		iter_tbl[it_idx] = indirect;
		mix = gen_a ^ gen_b;
		gen_a = gen_b + gen_count;
		gen_count = gen_count + 1;
		gen_b = gen_c + indirect;
		gen_c = mix + ((gen_c << ROT_AMOUNT) | (gen_c >> (WORD_W - ROT_AMOUNT)));
		return gen_b ^ iterated;
	endfunction

	// Writes one seed word into the predicted state. The last word of the
	// sequence runs the warm-up steps, whose outputs nobody sees, and sends
	// the position back to reg_a.
	function automatic void absorb_seed(input logic [SEED_W-1:0] w);
		word_t v;
		word_t discard;
		int unsigned base;
		v = word_t'(w);
		if (seed_pos == SEED_POS_A) begin
			gen_a = v;
		end else if (seed_pos == SEED_POS_B) begin
			gen_b = v;
		end else if (seed_pos == SEED_POS_C) begin
			gen_c = v;
		end else if (seed_pos == SEED_POS_I) begin
			gen_count = v;
		end else if (seed_pos < SEED_POS_TABLES + ITER_GROUPS) begin
			base = (seed_pos - SEED_POS_TABLES) * GROUP_SIZE;
			for (int k = 0; k < GROUP_SIZE; k++)
				if (base + k < ITER_DEPTH)
					iter_tbl[base + k] = v;
		end else begin
			indir_tbl[seed_pos - SEED_POS_TABLES - ITER_GROUPS] = v;
		end
		if (seed_pos + 1 >= SEED_WORDS) begin
			for (int k = 0; k < ITER_DEPTH; k++)
				discard = prng_advance();
			seed_pos = 0;
		end else begin
			seed_pos = seed_pos + 1;
		end
	endfunction

	// Seed values lean on the extremes now and then.
	function automatic logic [SEED_W-1:0] pick_seed_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		if (roll < 20)
			return '1;
		return $urandom();
	endfunction

	task automatic note_mismatch(input string what, input word_t want, input word_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// Offers one word on req and holds it until the core takes it. Valid is
	// left high on return, so a following word goes out back to back; the
	// next call either replaces the payload or drops valid while it idles,
	// and each is a single assignment in its own time step.
	task automatic send_word(input logic m, input logic [SEED_W-1:0] w);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.mode <= m;
		req_if.seed_word <= w;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (m == MODE_GEN)
			expected_values.push_back(prng_advance());
		else
			absorb_seed(w);
		words_sent++;
	endtask

	// Stops offering words and waits until every predicted output has come
	// back. It waits on the clock before it checks the queue, so valid is
	// never driven twice in one time step.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_values.size() != 0)
			@(posedge clk);
	endtask

	// Sends seed words until the current sequence is complete, starting
	// wherever the position stands now.
	task automatic finish_seeding(input int unsigned gen_percent);
		int unsigned left;
		left = SEED_WORDS - seed_pos;
		for (int k = 0; k < left; k++) begin
			if ($urandom_range(0, 99) < gen_percent)
				send_word(MODE_GEN, $urandom());
			send_word(MODE_SEED, pick_seed_value());
		end
	endtask

	// Straight after reset all state is zero, so the first outputs come
	// from an all-zero generator.
	task automatic test_unseeded_generate();
		send_word(MODE_GEN, '0);
		send_word(MODE_GEN, '1);
		send_word(MODE_GEN, $urandom());
	endtask

	// One full seed sequence built from extreme values. The counter starts
	// at the top of the 32-bit seed range and reg_c is all ones, so both table
	// indexes wrap. A generate request in the middle of the sequence must
	// use the half-written state and leave the position where it was. A
	// second sequence is then begun to show that seeding restarts at reg_a.
	task automatic test_seed_extremes();
		logic [SEED_W-1:0] w;
		for (int p = 0; p < SEED_WORDS; p++) begin
			w = (p % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555;
			if (p == SEED_POS_A || p == SEED_POS_C || p == SEED_POS_I)
				w = '1;
			else if (p == SEED_POS_B)
				w = '0;
			send_word(MODE_SEED, w);
			if (p == SEED_POS_TABLES + 1)
				send_word(MODE_GEN, $urandom());
		end
		repeat (3)
			send_word(MODE_GEN, $urandom());
		send_word(MODE_SEED, 32'h0000_0001);
		send_word(MODE_SEED, 32'h8000_0000);
		send_word(MODE_GEN, $urandom());
		finish_seeding(0);
		send_word(MODE_GEN, $urandom());
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	// A result waits on rsp, the core stops taking words once the next generate step stalls, and seed
	// words in the middle of the burst must still be handled in order.
	task automatic test_output_stall();
		stall_sink_req = 1'b1;
		repeat (4)
			send_word(MODE_GEN, $urandom());
		repeat (2)
			send_word(MODE_SEED, pick_seed_value());
		repeat (10)
			send_word(MODE_GEN, $urandom());
		wait_drained();
	endtask

	// Most of the traffic is complete seed sequences with random content,
	// sometimes with a generate request slipped in, each followed by a run of
	// generate requests. The rest is a loose mix of both kinds of word. At
	// the halfway point the sender pauses until the core has caught up, and
	// for one stretch neither side idles.
	task automatic test_random_traffic();
		int start;
		int run;
		bit paused;
		start = words_sent;
		paused = 1'b0;
		while (words_sent - start < RANDOM_WORDS) begin
			steady = (words_sent - start >= STEADY_FROM) && (words_sent - start < STEADY_TO);
			if ($urandom_range(0, 99) < 70) begin
				finish_seeding(8);
				run = $urandom_range(1, 24);
				repeat (run)
					send_word(MODE_GEN, $urandom());
			end else begin
				run = $urandom_range(1, 10);
				repeat (run)
					send_word(logic'($urandom_range(0, 1)), pick_seed_value());
			end
			if (!paused && words_sent - start >= RANDOM_WORDS / 2) begin
				paused = 1'b1;
				wait_drained();
			end
		end
		steady = 1'b0;
	endtask

	// Receiver: ready drops at random, except while steady is set or while a
	// requested hold-off is running.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_sink_req) begin
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					rsp_if.ready <= 1'b0;
					@(posedge clk);
				end
				stall_sink_req = 1'b0;
			end
			rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Every result the core hands over is matched against the oldest
	// prediction.
	always @(posedge clk) begin : check_results
		word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_values.size() == 0) begin
				note_mismatch("unexpected result", '0, rsp_if.random_value);
			end else begin
				want = expected_values.pop_front();
				if (rsp_if.random_value !== want)
					note_mismatch("random_value", want, rsp_if.random_value);
			end
		end
	end

	// Counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("[efiix64_random_generator_core] ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.mode <= MODE_SEED;
		req_if.seed_word <= '0;
		steady = 1'b0;
		stall_sink_req = 1'b0;
		predictor_reset();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unseeded_generate();
		test_seed_extremes();
		test_output_stall();
		test_random_traffic();

		wait_drained();
		// A trailing seed sequence may still be warming up; give it time
		// so that any stray result would show.
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("[efiix64_random_generator_core] OK");
		else
			$display("[efiix64_random_generator_core] ERROR");
		$finish;
	end

endmodule
